// File: rtl/assert_macros.svh
// Assertion macros shared by the hue/saturation classifier RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define HSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define HSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/hsc_pkg.sv
// Types and constants of the hue/saturation class table.
// Used by every module of the block except hsc_ram; no dependencies.
package hsc_pkg;

  localparam logic [1:0] KIND_CLASSIFY = 2'd0;
  localparam logic [1:0] KIND_WRITE    = 2'd1;
  localparam logic [1:0] KIND_FILL     = 2'd2;
  localparam logic [1:0] KIND_CLEAR    = 2'd3;

  localparam logic [1:0] CFG_HUE_LOW  = 2'd0;
  localparam logic [1:0] CFG_HUE_HIGH = 2'd1;
  localparam logic [1:0] CFG_SAT_LOW  = 2'd2;
  localparam logic [1:0] CFG_SAT_HIGH = 2'd3;

  localparam logic [7:0] CLASS_GREEN  = 8'd1;
  localparam logic [7:0] CLASS_ORANGE = 8'd2;
  localparam logic [7:0] CLASS_WHITE  = 8'd3;

  localparam logic [7:0] LEVEL_GREEN  = 8'd200;
  localparam logic [7:0] LEVEL_ORANGE = 8'd140;
  localparam logic [7:0] LEVEL_FULL   = 8'd255;

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] class_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] class_found;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       in_window;
  } out_item_t;

  // Decoded command as it sits in the queue
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] cls;
    logic [7:0] hue;
    logic [7:0] sat;
    logic       hit;
    logic       win;
    logic       empty;
    logic [7:0] h_lo;
    logic [7:0] h_hi;
    logic [7:0] s_lo;
    logic [7:0] s_hi;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_if_t;

endpackage

// File: rtl/hue_sat_color_class_lut.sv
// Classify, write, fill and clear: a classify result passes the queue and the registered table
// read and is shown for one cycle. Classify and write items sustain one per cycle while no fill
// or clear holds the engine; fills and clears write through the single RAM write port.
// Reset: synchronous; the table is then swept to zero with busy high.
// The receiver cannot stall; config writes are taken at any time.
// Depends on hsc_pkg, hsc_front, hsc_queue, hsc_back, hsc_ram and assert_macros.svh.
`include "assert_macros.svh"
module hue_sat_color_class_lut #(
  parameter int HUE_BINS = 256,
  parameter int SAT_BINS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  output hsc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import hsc_pkg::*;

  q_if_t q_push, q_head;
  logic  q_full, q_pop, init_busy, pop_cls;

  assign busy = init_busy | q_full;

  hsc_front #(
    .HUE_BINS(HUE_BINS),
    .SAT_BINS(SAT_BINS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .push     (q_push)
  );

  hsc_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .pop  (q_pop),
    .head (q_head),
    .full (q_full)
  );

  hsc_back #(
    .HUE_BINS(HUE_BINS),
    .SAT_BINS(SAT_BINS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .pop      (q_pop),
    .init_busy(init_busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  assign pop_cls = q_pop && (q_head.cmd.kind == KIND_CLASSIFY);

  `HSC_ASSERT_IMPL(a_out_from_read, clk, rst_n, out_valid, $past(pop_cls), "result without lookup")
  `HSC_ASSERT_NEXT(a_read_gives_out, clk, rst_n, pop_cls, out_valid, "lookup result lost")
  `HSC_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, q_pop, q_head.valid, "pop from empty queue")
endmodule

// File: rtl/hsc_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module hsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/hsc_front.sv
// Front end: window registers, input decode and rectangle clipping.
// Depends on hsc_pkg.
module hsc_front #(
  parameter int HUE_BINS = 256,
  parameter int SAT_BINS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  hsc_pkg::in_item_t in_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  output hsc_pkg::q_if_t    push
);
  import hsc_pkg::*;

  localparam logic [7:0] HUE_MAX = 8'(HUE_BINS - 1);
  localparam logic [7:0] SAT_MAX = 8'(SAT_BINS - 1);

  logic [7:0] hue_low_r, hue_high_r, sat_low_r, sat_high_r;
  logic [7:0] h_end, s_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r  <= 8'd0;
      hue_high_r <= 8'd255;
      sat_low_r  <= 8'd0;
      sat_high_r <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HUE_LOW:  hue_low_r  <= cfg_wdata;
        CFG_HUE_HIGH: hue_high_r <= cfg_wdata;
        CFG_SAT_LOW:  sat_low_r  <= cfg_wdata;
        CFG_SAT_HIGH: sat_high_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // clip the fill rectangle to the table
  assign h_end = (hue_high_r > HUE_MAX) ? HUE_MAX : hue_high_r;
  assign s_end = (sat_high_r > SAT_MAX) ? SAT_MAX : sat_high_r;

  always_comb begin
    push.valid     = start & ~busy;
    push.cmd.kind  = in_data.kind;
    push.cmd.cls   = in_data.class_value;
    push.cmd.hue   = in_data.hue;
    push.cmd.sat   = in_data.sat;
    push.cmd.hit   = (in_data.hue <= HUE_MAX) && (in_data.sat <= SAT_MAX);
    push.cmd.win   = (in_data.hue >= hue_low_r) && (in_data.hue <= hue_high_r) &&
                     (in_data.sat >= sat_low_r) && (in_data.sat <= sat_high_r);
    push.cmd.empty = (hue_low_r > h_end) || (sat_low_r > s_end);
    push.cmd.h_lo  = hue_low_r;
    push.cmd.h_hi  = h_end;
    push.cmd.s_lo  = sat_low_r;
    push.cmd.s_hi  = s_end;
  end
endmodule

// File: rtl/hsc_queue.sv
// Short command queue between front end and table engine.
// Depends on hsc_pkg.
module hsc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  hsc_pkg::q_if_t push,
  input  logic           pop,
  output hsc_pkg::q_if_t head,
  output logic           full
);
  import hsc_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(Q_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(Q_DEPTH);

  cmd_t          mem_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CNT_FULL);
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end
endmodule

// File: rtl/hsc_back.sv
// Table engine: runs lookups, writes, fill and clear sweeps on the class RAM.
// Depends on hsc_pkg and hsc_ram.
module hsc_back #(
  parameter int HUE_BINS = 256,
  parameter int SAT_BINS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hsc_pkg::q_if_t     head,
  output logic               pop,
  output logic               init_busy,
  output logic               out_valid,
  output hsc_pkg::out_item_t out_data
);
  import hsc_pkg::*;

  localparam int DEPTH = HUE_BINS * SAT_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

  typedef enum logic [1:0] {ST_RUN, ST_FILL, ST_CLEAR} state_t;

  state_t        state_r, state_nxt;
  logic          init_r, init_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [7:0]    h_r, s_r, h_hi_r, s_lo_r, s_hi_r, fcls_r;
  logic [7:0]    h_nxt, s_nxt, h_hi_nxt, s_lo_nxt, s_hi_nxt, fcls_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_hit_r, rd_hit_nxt, rd_win_r, rd_win_nxt;

  logic [7:0]    idx_h, idx_s;
  logic [AW-1:0] lin_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata, cls;

  assign idx_h    = (state_r == ST_FILL) ? h_r : head.cmd.hue;
  assign idx_s    = (state_r == ST_FILL) ? s_r : head.cmd.sat;
  assign lin_addr = AW'(idx_h) * AW'(SAT_BINS) + AW'(idx_s);

  hsc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(lin_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    init_nxt     = init_r;
    clr_addr_nxt = clr_addr_r;
    h_nxt        = h_r;
    s_nxt        = s_r;
    h_hi_nxt     = h_hi_r;
    s_lo_nxt     = s_lo_r;
    s_hi_nxt     = s_hi_r;
    fcls_nxt     = fcls_r;
    rd_pend_nxt  = 1'b0;
    rd_hit_nxt   = rd_hit_r;
    rd_win_nxt   = rd_win_r;
    pop          = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = lin_addr;
    ram_wdata    = head.cmd.cls;
    case (state_r)
      ST_RUN: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.cmd.kind)
            KIND_CLASSIFY: begin
              rd_pend_nxt = 1'b1;
              rd_hit_nxt  = head.cmd.hit;
              rd_win_nxt  = head.cmd.win;
            end
            KIND_WRITE: begin
              ram_we = head.cmd.hit;
            end
            KIND_FILL: begin
              if (!head.cmd.empty) begin
                state_nxt = ST_FILL;
                h_nxt     = head.cmd.h_lo;
                s_nxt     = head.cmd.s_lo;
                h_hi_nxt  = head.cmd.h_hi;
                s_lo_nxt  = head.cmd.s_lo;
                s_hi_nxt  = head.cmd.s_hi;
                fcls_nxt  = head.cmd.cls;
              end
            end
            KIND_CLEAR: begin
              state_nxt    = ST_CLEAR;
              clr_addr_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = fcls_r;
        // walk the rectangle row by row
        if (s_r == s_hi_r) begin
          s_nxt = s_lo_r;
          if (h_r == h_hi_r) begin
            state_nxt = ST_RUN;
          end else begin
            h_nxt = h_r + 8'd1;
          end
        end else begin
          s_nxt = s_r + 8'd1;
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = 8'd0;
        if (clr_addr_r == ADDR_LAST) begin
          state_nxt = ST_RUN;
          init_nxt  = 1'b0;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      init_r     <= 1'b1;
      clr_addr_r <= '0;
      rd_pend_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      init_r     <= init_nxt;
      clr_addr_r <= clr_addr_nxt;
      rd_pend_r  <= rd_pend_nxt;
    end
    h_r      <= h_nxt;
    s_r      <= s_nxt;
    h_hi_r   <= h_hi_nxt;
    s_lo_r   <= s_lo_nxt;
    s_hi_r   <= s_hi_nxt;
    fcls_r   <= fcls_nxt;
    rd_hit_r <= rd_hit_nxt;
    rd_win_r <= rd_win_nxt;
  end

  assign init_busy = init_r;
  assign out_valid = rd_pend_r;
  assign cls       = rd_hit_r ? ram_rdata : 8'd0;

  always_comb begin
    out_data.class_found = cls;
    out_data.in_window   = rd_win_r;
    out_data.blue_out    = 8'd0;
    out_data.green_out   = 8'd0;
    out_data.red_out     = 8'd0;
    case (cls)
      CLASS_GREEN: begin
        out_data.green_out = LEVEL_GREEN;
      end
      CLASS_ORANGE: begin
        out_data.green_out = LEVEL_ORANGE;
        out_data.red_out   = LEVEL_FULL;
      end
      CLASS_WHITE: begin
        out_data.blue_out  = LEVEL_FULL;
        out_data.green_out = LEVEL_FULL;
        out_data.red_out   = LEVEL_FULL;
      end
      default: begin
      end
    endcase
  end
endmodule

// File: dv/hue_sat_color_class_lut_test.sv
`timescale 1ns / 100ps
// Testbench for hue_sat_color_class_lut: a directed table, then random phases under changing
// windows, each classify result checked against a directed expectation or a behavioral class table.
// Depends on hsc_pkg and the hue_sat_color_class_lut RTL.
module hue_sat_color_class_lut_test;
  import hsc_pkg::*;

  localparam int HUE_BINS      = 256;
  localparam int SAT_BINS      = 256;
  localparam int TABLE_SIZE    = HUE_BINS * SAT_BINS;
  localparam int N_PHASES      = 12;
  localparam int PHASE_ITEMS   = 138;
  localparam int MAX_FILL_AREA = 512;
  localparam int MAX_CLEARS    = 2;
  localparam int IDLE_LIMIT    = 400000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      start     = 1'b0;
  in_item_t  in_data   = '0;
  logic      cfg_we    = 1'b0;
  logic [1:0] cfg_index = CFG_HUE_LOW;
  logic [7:0] cfg_wdata = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;

  always #2 clk = ~clk;

  hue_sat_color_class_lut #(
    .HUE_BINS(HUE_BINS),
    .SAT_BINS(SAT_BINS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow of the class table and window registers
  logic [7:0] class_mem [TABLE_SIZE];
  logic [7:0] hue_lo = 8'd0;
  logic [7:0] hue_hi = 8'd255;
  logic [7:0] sat_lo = 8'd0;
  logic [7:0] sat_hi = 8'd255;

  out_item_t pending_results [$];
  int        recent_costs [$];
  dir_row_t  directed [$];
  int        mismatches  = 0;
  int        idle_cycles = 0;
  int        burst_left  = 1;
  int        clears_left = MAX_CLEARS;
  logic [7:0] hot_h, hot_s;

  function automatic int fill_area();
    int h_end, s_end;
    h_end = (hue_hi > HUE_BINS - 1) ? HUE_BINS - 1 : hue_hi;
    s_end = (sat_hi > SAT_BINS - 1) ? SAT_BINS - 1 : sat_hi;
    if (hue_lo > h_end || sat_lo > s_end) return 0;
    return (h_end - hue_lo + 1) * (s_end - sat_lo + 1);
  endfunction

  // Busy cycles a transaction may keep the table engine going
  function automatic int item_cost(in_item_t it);
    int area;
    area = fill_area();
    case (it.kind)
      KIND_FILL:  return (area > 0) ? area : 1;
      KIND_CLEAR: return TABLE_SIZE;
      default:    return 1;
    endcase
  endfunction

  task automatic update_table(input in_item_t it, output bit has_res, output out_item_t res);
    int h, s, i, j, h_end, s_end;
    logic [7:0] cls;
    h = it.hue;
    s = it.sat;
    has_res = 1'b0;
    res = '0;
    h_end = (hue_hi > HUE_BINS - 1) ? HUE_BINS - 1 : hue_hi;
    s_end = (sat_hi > SAT_BINS - 1) ? SAT_BINS - 1 : sat_hi;
    case (it.kind)
      KIND_WRITE: begin
        if (h < HUE_BINS && s < SAT_BINS) class_mem[h * SAT_BINS + s] = it.class_value;
      end
      KIND_FILL: begin
        for (i = hue_lo; i <= h_end; i++)
          for (j = sat_lo; j <= s_end; j++)
            class_mem[i * SAT_BINS + j] = it.class_value;
      end
      KIND_CLEAR: begin
        for (i = 0; i < TABLE_SIZE; i++) class_mem[i] = '0;
      end
      default: begin
        cls = (h < HUE_BINS && s < SAT_BINS) ? class_mem[h * SAT_BINS + s] : 8'd0;
        res.class_found = cls;
        case (cls)
          CLASS_GREEN:  res.green_out = LEVEL_GREEN;
          CLASS_ORANGE: begin
            res.green_out = LEVEL_ORANGE;
            res.red_out   = LEVEL_FULL;
          end
          CLASS_WHITE: begin
            res.blue_out  = LEVEL_FULL;
            res.green_out = LEVEL_FULL;
            res.red_out   = LEVEL_FULL;
          end
          default: ;
        endcase
        res.in_window = (it.hue >= hue_lo && it.hue <= hue_hi &&
                         it.sat >= sat_lo && it.sat <= sat_hi);
        has_res = 1'b1;
      end
    endcase
  endtask

  function automatic dir_row_t op(logic [1:0] k, int h, int s, int c);
    dir_row_t row;
    row = '0;
    row.item.kind        = k;
    row.item.hue         = h[7:0];
    row.item.sat         = s[7:0];
    row.item.class_value = c[7:0];
    return row;
  endfunction

  function automatic dir_row_t chk(int h, int s, int cls, int b, int g, int r, logic w);
    dir_row_t row;
    row = op(KIND_CLASSIFY, h, s, 0);
    row.typed           = 1'b1;
    row.res.class_found = cls[7:0];
    row.res.blue_out    = b[7:0];
    row.res.green_out   = g[7:0];
    row.res.red_out     = r[7:0];
    row.res.in_window   = w;
    return row;
  endfunction

  // Drive one transaction, hold until taken, then pace the sender in bursts
  task automatic send(in_item_t it, bit typed, out_item_t typed_res);
    bit has_res;
    out_item_t res;
    int gap;
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    update_table(it, has_res, res);
    if (has_res) pending_results.push_back(typed ? typed_res : res);
    recent_costs.push_back(item_cost(it));
    if (recent_costs.size() > 8) void'(recent_costs.pop_front());
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Drain results, then give fills and clears time to finish
  task automatic settle();
    int wait_cycles;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    wait_cycles = 32;
    foreach (recent_costs[i]) wait_cycles += recent_costs[i];
    recent_costs.delete();
    repeat (wait_cycles) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_HUE_LOW:  hue_lo = val;
      CFG_HUE_HIGH: hue_hi = val;
      CFG_SAT_LOW:  sat_lo = val;
      default:      sat_hi = val;
    endcase
  endtask

  task automatic set_window(int hl, int hh, int sl, int sh);
    write_cfg(CFG_HUE_LOW,  hl[7:0]);
    write_cfg(CFG_HUE_HIGH, hh[7:0]);
    write_cfg(CFG_SAT_LOW,  sl[7:0]);
    write_cfg(CFG_SAT_HIGH, sh[7:0]);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] near(logic [7:0] base);
    int v;
    v = int'(base) + $urandom_range(0, 11) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic pick_item(output in_item_t it);
    int r;
    r = $urandom_range(0, 999);
    if (r < 550)      it.kind = KIND_CLASSIFY;
    else if (r < 870) it.kind = KIND_WRITE;
    else if (r < 997) it.kind = (fill_area() <= MAX_FILL_AREA) ? KIND_FILL : KIND_WRITE;
    else if (clears_left > 0) begin
      it.kind = KIND_CLEAR;
      clears_left--;
    end else it.kind = KIND_CLASSIFY;
    // Most coordinates land near the window so reads hit written entries
    it.hue = ($urandom_range(0, 9) < 6) ? near(hot_h) : 8'($urandom_range(0, 255));
    it.sat = ($urandom_range(0, 9) < 6) ? near(hot_s) : 8'($urandom_range(0, 255));
    it.class_value = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 4))
                                                : 8'($urandom_range(0, 255));
  endtask

  task automatic pick_window(int ph, output int hl, output int hh, output int sl, output int sh);
    case (ph)
      0: begin hl = 0;   hh = 255; sl = 0;   sh = 255; end
      1: begin hl = 255; hh = 255; sl = 255; sh = 255; end
      2: begin hl = 0;   hh = 0;   sl = 0;   sh = 0;   end
      3: begin
        // Low bound above high bound: fills write nothing
        hl = $urandom_range(8, 255);
        hh = hl - $urandom_range(1, 8);
        sl = $urandom_range(0, 248);
        sh = sl + $urandom_range(0, 7);
      end
      default: begin
        hl = $urandom_range(0, 255);
        hh = ($urandom_range(0, 5) == 0 && hl > 0) ? hl - 1 : hl + $urandom_range(0, 7);
        sl = $urandom_range(0, 255);
        sh = ($urandom_range(0, 5) == 0 && sl > 0) ? sl - 1 : sl + $urandom_range(0, 7);
        if (hh > 255) hh = 255;
        if (sh > 255) sh = 255;
      end
    endcase
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected classify result: cls=%0d b=%0d g=%0d r=%0d win=%0b",
                   out_data.class_found, out_data.blue_out, out_data.green_out,
                   out_data.red_out, out_data.in_window);
      end else begin
        want = pending_results.pop_front();
        if (want.class_found !== out_data.class_found || want.blue_out !== out_data.blue_out ||
            want.green_out !== out_data.green_out || want.red_out !== out_data.red_out ||
            want.in_window !== out_data.in_window) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("classify mismatch: expected cls=%0d b=%0d g=%0d r=%0d win=%0b,",
                     want.class_found, want.blue_out, want.green_out, want.red_out,
                     want.in_window,
                     " got cls=%0d b=%0d g=%0d r=%0d win=%0b",
                     out_data.class_found, out_data.blue_out,
                     out_data.green_out, out_data.red_out, out_data.in_window);
        end
      end
    end
  end

  // Clears and the reset sweep run with no transaction; the idle limit allows several
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t it;
    int hl, hh, sl, sh;
    foreach (class_mem[i]) class_mem[i] = '0;
    directed = '{
      chk(0, 0, 0, 0, 0, 0, 1'b1),
      chk(255, 255, 0, 0, 0, 0, 1'b1),
      op(KIND_CLASSIFY, 128, 64, 0),
      op(KIND_WRITE, 0, 0, CLASS_GREEN),
      op(KIND_WRITE, 255, 255, CLASS_ORANGE),
      op(KIND_WRITE, 0, 255, CLASS_WHITE),
      op(KIND_WRITE, 255, 0, 255),
      op(KIND_WRITE, 128, 64, 4),
      chk(0, 0, CLASS_GREEN, 0, LEVEL_GREEN, 0, 1'b1),
      chk(255, 255, CLASS_ORANGE, 0, LEVEL_ORANGE, LEVEL_FULL, 1'b1),
      chk(0, 255, CLASS_WHITE, LEVEL_FULL, LEVEL_FULL, LEVEL_FULL, 1'b1),
      chk(255, 0, 255, 0, 0, 0, 1'b1),
      chk(128, 64, 4, 0, 0, 0, 1'b1),
      op(KIND_WRITE, 0, 0, 0),
      op(KIND_CLASSIFY, 0, 0, 0),
      op(KIND_FILL, 0, 0, CLASS_WHITE),
      chk(17, 200, CLASS_WHITE, LEVEL_FULL, LEVEL_FULL, LEVEL_FULL, 1'b1),
      op(KIND_CLASSIFY, 255, 0, 0),
      op(KIND_CLEAR, 0, 0, 0),
      chk(255, 255, 0, 0, 0, 0, 1'b1),
      op(KIND_WRITE, 7, 9, CLASS_ORANGE),
      chk(7, 9, CLASS_ORANGE, 0, LEVEL_ORANGE, LEVEL_FULL, 1'b1),
      op(KIND_CLASSIFY, 7, 10, 0)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Hold off until the table sweep after reset completes
    while (busy !== 1'b0) @(posedge clk);

    foreach (directed[i]) send(directed[i].item, directed[i].typed, directed[i].res);
    settle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      pick_window(ph, hl, hh, sl, sh);
      set_window(hl, hh, sl, sh);
      hot_h = hl[7:0];
      hot_s = sl[7:0];
      repeat (PHASE_ITEMS) begin
        pick_item(it);
        send(it, 1'b0, '0);
      end
      settle();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
